@@ src/cpps_pkg.sv @@
// Shared types and constants for the closest prime pair sieve core.
// No dependencies.
package cpps_pkg;

    typedef logic [15:0]        t_num;
    typedef logic signed [16:0] t_res;

    // Gap tracker starts from this value; a pair is kept only if its gap is smaller.
    localparam t_num GAP_START = 16'd32767;
    localparam t_res RES_NONE  = -17'sd1;

    typedef struct packed {
        logic clear;   // start a new range
        logic hit;     // n is prime and in range
        t_num n;
    } t_gap_ctl;

endpackage

@@ src/cpps_map.sv @@
// One-bit-per-number primality store, one write port and one registered read port.
// Depends on nothing.
module cpps_map #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [0:DEPTH-1];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/cpps_gap.sv @@
// Running tracker of the closest adjacent prime pair over an ascending scan.
// Depends on cpps_pkg.
module cpps_gap
    import cpps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_gap_ctl i_ctl,
    output t_res     o_lower,
    output t_res     o_upper
);

    logic r_prev_v;
    t_num r_prev;
    t_num r_best_gap;
    t_res r_lo;
    t_res r_hi;
    t_num gap;

    assign gap = i_ctl.n - r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_prev_v   <= 1'b0;
            r_prev     <= '0;
            r_best_gap <= GAP_START;
            r_lo       <= RES_NONE;
            r_hi       <= RES_NONE;
        end else if (i_ctl.hit) begin
            if (r_prev_v && gap < r_best_gap) begin
                r_best_gap <= gap;
                r_lo       <= signed'({1'b0, r_prev});
                r_hi       <= signed'({1'b0, i_ctl.n});
            end
            r_prev   <= i_ctl.n;
            r_prev_v <= 1'b1;
        end
    end

    assign o_lower = r_lo;
    assign o_upper = r_hi;

endmodule

@@ src/closest_prime_pair_sieve_core.sv @@
// Closest adjacent prime pair in [low, high] via a sieve in a 1-bit memory.
// Steps: (L+1) fill writes, a check and a read per p with p*p <= L, one write per strike and
// one closing check, then (L-low+1) scan reads, a drain and the result; L = min(high, MAX_VALUE).
// One request at a time. The memory port sets the pace.
// Synchronous active-low reset returns the sequencer to idle; the store is rebuilt per request.
module closest_prime_pair_sieve_core
    import cpps_pkg::*;
#(
    parameter int MAX_VALUE = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_range_low,
    input  logic [15:0] i_range_high,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [16:0] o_lower_prime,
    output logic signed [16:0] o_upper_prime
);

    localparam int   DEPTH     = MAX_VALUE + 1;
    localparam int   AW        = $clog2(DEPTH);
    localparam t_num LIMIT_CAP = (MAX_VALUE > 65535) ? 16'hFFFF : 16'(MAX_VALUE);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FILL   = 3'd1;
    localparam logic [2:0] ST_PCHK   = 3'd2;
    localparam logic [2:0] ST_PRD    = 3'd3;
    localparam logic [2:0] ST_STRIKE = 3'd4;
    localparam logic [2:0] ST_SCAN   = 3'd5;
    localparam logic [2:0] ST_DRAIN  = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    logic [2:0]  r_state, n_state;
    t_num        r_low, n_low;
    t_num        r_limit, n_limit;
    t_num        r_n, n_n;
    logic [8:0]  r_p, n_p;
    logic [16:0] r_m, n_m;
    logic        r_iss_v;
    t_num        r_iss_n;
    logic        r_out_v, n_out_v;
    t_res        r_out_lo, r_out_hi;

    logic        accept;
    t_num        sat_high;
    logic [17:0] sq;
    logic [16:0] next_m;
    logic        load_out;

    logic          we;
    logic [AW-1:0] waddr;
    logic          wdata;
    logic [AW-1:0] raddr;
    logic          rdata;

    t_gap_ctl gap_ctl;
    t_res     gap_lo;
    t_res     gap_hi;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign sat_high = (i_range_high > LIMIT_CAP) ? LIMIT_CAP : i_range_high;
    assign sq       = r_p * r_p;
    assign next_m   = r_m + {8'd0, r_p};
    assign load_out = (r_state == ST_FIN) && (!r_out_v || i_ready);

    always_comb begin
        n_state = r_state;
        n_low   = r_low;
        n_limit = r_limit;
        n_n     = r_n;
        n_p     = r_p;
        n_m     = r_m;
        we      = 1'b0;
        waddr   = AW'(r_n);
        wdata   = 1'b0;
        raddr   = AW'(r_n);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_low   = i_range_low;
                    n_limit = sat_high;
                    n_n     = '0;
                    n_state = (i_range_low > sat_high) ? ST_FIN : ST_FILL;
                end
            end
            ST_FILL: begin
                // 0 and 1 go in as composite, everything else starts prime
                we    = 1'b1;
                wdata = (r_n > 16'd1);
                if (r_n == r_limit) begin
                    n_p     = 9'd2;
                    n_state = ST_PCHK;
                end else begin
                    n_n = r_n + 16'd1;
                end
            end
            ST_PCHK: begin
                raddr = AW'(r_p);
                n_m   = sq[16:0];
                if (sq > {2'b00, r_limit}) begin
                    n_n     = r_low;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_PRD;
                end
            end
            ST_PRD: begin
                if (rdata) begin
                    n_state = ST_STRIKE;
                end else begin
                    n_p     = r_p + 9'd1;
                    n_state = ST_PCHK;
                end
            end
            ST_STRIKE: begin
                we    = 1'b1;
                waddr = AW'(r_m[15:0]);
                wdata = 1'b0;
                if (next_m > {1'b0, r_limit}) begin
                    n_p     = r_p + 9'd1;
                    n_state = ST_PCHK;
                end else begin
                    n_m = next_m;
                end
            end
            ST_SCAN: begin
                raddr = AW'(r_n);
                if (r_n == r_limit) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_n = r_n + 16'd1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_v = r_out_v;
        if (load_out) begin
            n_out_v = 1'b1;
        end else if (r_out_v && i_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iss_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iss_v <= (r_state == ST_SCAN);
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low   <= n_low;
        r_limit <= n_limit;
        r_n     <= n_n;
        r_p     <= n_p;
        r_m     <= n_m;
        r_iss_n <= r_n;
        if (load_out) begin
            r_out_lo <= gap_lo;
            r_out_hi <= gap_hi;
        end
    end

    // read data lands in the cycle after issue, tagged with the number it belongs to
    assign gap_ctl.clear = accept;
    assign gap_ctl.hit   = r_iss_v && rdata;
    assign gap_ctl.n     = r_iss_n;

    cpps_map #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cpps_gap u_gap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gap_ctl),
        .o_lower (gap_lo),
        .o_upper (gap_hi)
    );

    assign o_valid       = r_out_v;
    assign o_lower_prime = r_out_lo;
    assign o_upper_prime = r_out_hi;

endmodule

@@ test/closest_prime_pair_sieve_core_tb.sv @@
// Self-checking bench for closest_prime_pair_sieve_core: directed range table, then random ranges.
// Expected pairs come from the table rows or an in-bench sieve; depends on cpps_pkg and the core only.
`timescale 1ns / 1ps

module closest_prime_pair_sieve_core_tb
    import cpps_pkg::*;
();

    localparam int SIEVE_MAX   = 65535;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int RANDOM_REQS = 80;
    localparam int NUM_TABLE   = 20;

    typedef struct packed {
        t_res lo;
        t_res hi;
    } t_pair;

    typedef struct {
        int low;
        int high;
        bit typed;   // expected pair written in the row
        int exp_lo;
        int exp_hi;
    } t_range_case;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_range_low;
    logic [15:0] i_range_high;
    logic        o_valid;
    logic        i_ready;
    logic signed [16:0] o_lower_prime;
    logic signed [16:0] o_upper_prime;

    t_pair pending_pairs[$];
    bit    sieve_map [0:SIEVE_MAX];
    int    mismatches = 0;
    int    cycles = 0;
    bit    steady = 1'b0;   // no idling on either side while set
    bit    in_reset = 1'b1;

    t_range_case range_table [0:NUM_TABLE-1] = '{
        '{0,     0,     1, -1, -1},
        '{0,     1,     1, -1, -1},
        '{0,     2,     1, -1, -1},
        '{2,     3,     1,  2,  3},
        '{0,     10,    1,  2,  3},
        '{3,     7,     1,  3,  5},   // tie: first pair wins
        '{5,     0,     1, -1, -1},
        '{65535, 0,     1, -1, -1},
        '{1,     0,     1, -1, -1},
        '{24,    28,    1, -1, -1},
        '{23,    29,    1, 23, 29},
        '{89,    97,    1, 89, 97},
        '{113,   127,   1, 113, 127},
        '{7,     7,     1, -1, -1},
        '{4,     4,     1, -1, -1},
        '{0,     100,   0,  0,  0},
        '{100,   200,   0,  0,  0},
        '{500,   600,   0,  0,  0},
        '{65535, 65535, 1, -1, -1},
        '{0,     65535, 1,  2,  3}
    };

    closest_prime_pair_sieve_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_lower_prime (o_lower_prime),
        .o_upper_prime (o_upper_prime)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sieve up to the upper bound, then keep the first adjacent pair with the smallest gap.
    function automatic t_pair find_closest_pair(input int low, input int high);
        t_pair pair;
        int    n;
        int    p;
        int    m;
        int    prev;
        int    best;
        bit    have_prev;
        pair.lo = RES_NONE;
        pair.hi = RES_NONE;
        if (high > SIEVE_MAX) high = SIEVE_MAX;
        if (low > high) return pair;
        for (n = 0; n <= high; n++) sieve_map[n] = 1'b1;
        sieve_map[0] = 1'b0;
        if (high >= 1) sieve_map[1] = 1'b0;
        for (p = 2; p * p <= high; p++) begin
            if (sieve_map[p]) begin
                for (m = p * p; m <= high; m += p) sieve_map[m] = 1'b0;
            end
        end
        have_prev = 1'b0;
        prev = 0;
        best = int'(GAP_START);
        for (n = low; n <= high; n++) begin
            if (sieve_map[n]) begin
                if (have_prev && (n - prev) < best) begin
                    best = n - prev;
                    pair.lo = t_res'(prev);
                    pair.hi = t_res'(n);
                end
                prev = n;
                have_prev = 1'b1;
            end
        end
        return pair;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_range(input int low, input int high, input t_pair expected);
        int wait_cycles;
        wait_cycles = steady ? 0 : $urandom_range(0, 9);
        if (wait_cycles > 0) begin
            i_valid <= 1'b0;
            repeat (wait_cycles) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_range_low  <= 16'(low);
        i_range_high <= 16'(high);
        do @(posedge i_clk); while (!o_ready);
        pending_pairs.insert(pending_pairs.size(), expected);
        @(negedge i_clk);
    endtask

    task automatic drain_pairs();
        while (pending_pairs.size() > 0) @(negedge i_clk);
    endtask

    // Result side: random stall per result while not steady, then hold ready until one is taken.
    initial begin
        int    stall;
        t_pair want;
        i_ready = 1'b0;
        wait (!in_reset);
        @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (pending_pairs.size() == 0) begin
                $error("result with no request outstanding: %0d %0d",
                       o_lower_prime, o_upper_prime);
                mismatches++;
            end else begin
                want = pending_pairs.pop_front();
                if (o_lower_prime !== want.lo) begin
                    $error("lower_prime: expected %0d, got %0d", want.lo, o_lower_prime);
                    mismatches++;
                end
                if (o_upper_prime !== want.hi) begin
                    $error("upper_prime: expected %0d, got %0d", want.hi, o_upper_prime);
                    mismatches++;
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        int    i;
        int    kind;
        int    low;
        int    high;
        t_pair expected;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_range_low  = '0;
        i_range_high = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        in_reset = 1'b0;
        @(negedge i_clk);

        for (i = 0; i < NUM_TABLE; i++) begin
            if (range_table[i].typed) begin
                expected.lo = t_res'(range_table[i].exp_lo);
                expected.hi = t_res'(range_table[i].exp_hi);
            end else begin
                expected = find_closest_pair(range_table[i].low, range_table[i].high);
            end
            send_range(range_table[i].low, range_table[i].high, expected);
        end
        i_valid <= 1'b0;
        drain_pairs();

        for (i = 0; i < RANDOM_REQS; i++) begin
            if (i % 20 == 10) steady = ~steady;
            if (i == 60) begin
                i_valid <= 1'b0;
                drain_pairs();
            end
            kind = $urandom_range(0, 99);
            if (i == 50) begin
                // one wide sieve in the random part; most requests stay small
                high = $urandom_range(32768, SIEVE_MAX);
                low  = high - $urandom_range(0, 200);
            end else if (kind < 5) begin
                high = $urandom_range(600, 4095);
                low  = $urandom_range(0, high);
            end else if (kind < 15) begin
                high = $urandom_range(0, 600);
                low  = $urandom_range(high + 1, SIEVE_MAX);   // inverted range
            end else if (kind < 35) begin
                high = $urandom_range(0, 600);
                low  = high - $urandom_range(0, (high < 30) ? high : 30);
            end else begin
                high = $urandom_range(0, 600);
                low  = $urandom_range(0, high);
            end
            send_range(low, high, find_closest_pair(low, high));
        end
        i_valid <= 1'b0;
        steady = 1'b0;

        drain_pairs();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
